// ----- hw/rtl/lidar_scan_cluster_centroids_macros.svh -----
// Assertion macros for the lidar scan clustering block.
// Taken in by the checker; needs nothing else.
`ifndef LIDAR_SCAN_CLUSTER_CENTROIDS_MACROS_SVH
`define LIDAR_SCAN_CLUSTER_CENTROIDS_MACROS_SVH

// same-cycle implication, off while in reset
`define LSCC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("lscc: check failed");

// next-cycle implication, off while in reset
`define LSCC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("lscc: check failed");

// implication that also holds during reset
`define LSCC_ASSERT_RST(lbl, ck, ante, cons) \
	lbl: assert property (@(posedge ck) (ante) |-> (cons)) \
		else $error("lscc: check failed");

`endif

// ----- hw/rtl/lscc_pkg.sv -----
// Shared types, constants and the arctangent table of the clustering block.
// Depends on nothing.
package lscc_pkg;

	localparam int MAX_SAMPLES_DEF = 2048;

	localparam int unsigned TWO_PI_U = 6588397;
	localparam logic signed [23:0] ANG_TWO_PI  = 24'sd6588397;
	localparam logic signed [23:0] ANG_PI      = 24'sd3294199;
	localparam logic signed [23:0] ANG_HALF_PI = 24'sd1647099;

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [4:0] CORDIC_LAST = 5'd19;

	localparam logic [11:0] COUNT_MAX = 12'd4095;
	localparam logic signed [16:0] COORD_MIN = 17'sh10000;
	localparam logic signed [16:0] COORD_MAX = 17'sh0FFFF;

	localparam logic [2:0] REG_START_ANGLE   = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP    = 3'd1;
	localparam logic [2:0] REG_JOIN_DISTANCE = 3'd2;
	localparam logic [2:0] REG_MIN_POINTS    = 3'd3;
	localparam logic [2:0] REG_MAX_POINTS    = 3'd4;
	localparam logic [2:0] REG_MIN_WIDTH     = 3'd5;
	localparam logic [2:0] REG_MAX_WIDTH     = 3'd6;

	typedef struct packed {
		logic signed [22:0] start_angle;
		logic [15:0]        angle_step;
		logic [15:0]        join_distance;
		logic [11:0]        pts_min;
		logic [11:0]        pts_max;
		logic [16:0]        min_width;
		logic [16:0]        max_width;
	} cfg_t;

	typedef struct packed {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic               ok;
		logic               last;
	} point_t;

	typedef struct packed {
		logic signed [16:0] cx;
		logic signed [16:0] cy;
		logic               found;
		logic               scan_end;
	} result_t;

	function automatic logic [19:0] atan_lut(input logic [4:0] i);
		logic [19:0] v;
		case (i)
			5'd0:  v = 20'd823550;
			5'd1:  v = 20'd486170;
			5'd2:  v = 20'd256879;
			5'd3:  v = 20'd130396;
			5'd4:  v = 20'd65451;
			5'd5:  v = 20'd32757;
			5'd6:  v = 20'd16383;
			5'd7:  v = 20'd8192;
			5'd8:  v = 20'd4096;
			5'd9:  v = 20'd2048;
			5'd10: v = 20'd1024;
			5'd11: v = 20'd512;
			5'd12: v = 20'd256;
			5'd13: v = 20'd128;
			5'd14: v = 20'd64;
			5'd15: v = 20'd32;
			5'd16: v = 20'd16;
			5'd17: v = 20'd8;
			5'd18: v = 20'd4;
			5'd19: v = 20'd2;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/lscc_queue.sv -----
// Small first-in first-out queue of packed words.
// Depends on nothing; the word type is a parameter.
module lscc_queue #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	output logic full,
	input  logic rd_en,
	output T     rd_data,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/lscc_front.sv -----
// Front end: takes samples, forms the angle, runs the CORDIC and scales to x/y.
// Depends on lscc_pkg.
module lscc_front #(
	parameter int MAX_SAMPLES = lscc_pkg::MAX_SAMPLES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lscc_pkg::cfg_t  cfg,
	input  logic            push,
	output logic            full,
	input  logic [15:0]     range_mm,
	input  logic            range_ok,
	input  logic            scan_last,
	output logic            pt_push,
	output lscc_pkg::point_t pt,
	input  logic            pt_full
);
	import lscc_pkg::*;

	localparam int IW = $clog2(MAX_SAMPLES);
	localparam int AW = (IW + 17 > 25) ? IW + 17 : 25;
	localparam int RED_STEPS = AW - 22;
	localparam int KW = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
	localparam logic [AW-1:0] TWO_PI_W = AW'(TWO_PI_U);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL  = 3'd1;
	localparam logic [2:0] F_RED  = 3'd2;
	localparam logic [2:0] F_FOLD = 3'd3;
	localparam logic [2:0] F_ROT  = 3'd4;
	localparam logic [2:0] F_SC   = 3'd5;
	localparam logic [2:0] F_OUT  = 3'd6;

	logic [2:0]          state_q;
	logic [IW-1:0]       index_q, idx_q;
	logic [15:0]         range_q;
	logic                ok_q, last_q;
	logic [AW-1:0]       ang_q;
	logic [KW-1:0]       k_q;
	logic [4:0]          step_q;
	logic signed [23:0]  z_q;
	logic signed [31:0]  cx_q, cy_q;
	logic                neg_q;
	logic signed [19:0]  px_q, py_q;

	logic [IW+15:0]      prod;
	logic [AW-1:0]       red_sub;
	logic signed [23:0]  z0, z1;
	logic signed [31:0]  sh_x, sh_y, c_v, s_v;
	logic signed [23:0]  atan_v;
	logic signed [48:0]  mx, my;

	function automatic logic signed [16:0] clamp_c(input logic signed [19:0] v);
		logic signed [16:0] r;
		if (v < 20'(COORD_MIN)) r = COORD_MIN;
		else if (v > 20'(COORD_MAX)) r = COORD_MAX;
		else r = 17'(v);
		return r;
	endfunction

	assign full    = (state_q != F_IDLE);
	assign prod    = idx_q * cfg.angle_step;
	assign red_sub = TWO_PI_W << k_q;
	assign z0      = $signed({1'b0, ang_q[22:0]});
	assign z1      = (z0 >= ANG_PI) ? z0 - ANG_TWO_PI : z0;
	assign sh_x    = cx_q >>> step_q;
	assign sh_y    = cy_q >>> step_q;
	assign atan_v  = $signed({4'b0000, atan_lut(step_q)});
	assign c_v     = neg_q ? -cx_q : cx_q;
	assign s_v     = neg_q ? -cy_q : cy_q;
	assign mx      = $signed({1'b0, range_q}) * c_v;
	assign my      = $signed({1'b0, range_q}) * s_v;

	assign pt_push = (state_q == F_OUT) && !pt_full;
	assign pt.x    = clamp_c(px_q);
	assign pt.y    = clamp_c(py_q);
	assign pt.ok   = ok_q;
	assign pt.last = last_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				range_q <= range_mm;
				ok_q    <= range_ok;
				last_q  <= scan_last;
				idx_q   <= index_q;
			end
			F_MUL: begin
				ang_q <= AW'(prod) + AW'(cfg.start_angle) + TWO_PI_W;
				k_q   <= KW'(RED_STEPS - 1);
			end
			F_RED: begin
				if (ang_q >= red_sub) begin
					ang_q <= ang_q - red_sub;
				end
				k_q <= k_q - 1'b1;
			end
			F_FOLD: begin
				// fold into the right half plane; both outputs flip sign
				if (z1 > ANG_HALF_PI) begin
					z_q <= z1 - ANG_PI;
					neg_q <= 1'b1;
				end else if (z1 < -ANG_HALF_PI) begin
					z_q <= z1 + ANG_PI;
					neg_q <= 1'b1;
				end else begin
					z_q <= z1;
					neg_q <= 1'b0;
				end
				cx_q   <= CORDIC_GAIN;
				cy_q   <= '0;
				step_q <= '0;
			end
			F_ROT: begin
				if (z_q >= 0) begin
					cx_q <= cx_q - sh_y;
					cy_q <= cy_q + sh_x;
					z_q  <= z_q - atan_v;
				end else begin
					cx_q <= cx_q + sh_y;
					cy_q <= cy_q - sh_x;
					z_q  <= z_q + atan_v;
				end
				step_q <= step_q + 1'b1;
			end
			F_SC: begin
				px_q <= 20'((mx + 49'sd536870912) >>> 30);
				py_q <= 20'((my + 49'sd536870912) >>> 30);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			index_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						if (scan_last) index_q <= '0;
						else if (index_q == IW'(MAX_SAMPLES - 1)) index_q <= '0;
						else index_q <= index_q + 1'b1;
						state_q <= range_ok ? F_MUL : F_OUT;
					end
				end
				F_MUL:  state_q <= F_RED;
				F_RED:  if (k_q == '0) state_q <= F_FOLD;
				F_FOLD: state_q <= F_ROT;
				F_ROT:  if (step_q == CORDIC_LAST) state_q <= F_SC;
				F_SC:   state_q <= F_OUT;
				F_OUT:  if (!pt_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/lscc_back.sv -----
// Back end: distance test, cluster accumulation, acceptance and centroid division.
// Depends on lscc_pkg.
module lscc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lscc_pkg::cfg_t    cfg,
	input  logic              pt_empty,
	input  lscc_pkg::point_t  pt,
	output logic              pt_pop,
	output logic              res_push,
	output lscc_pkg::result_t res,
	input  logic              res_full
);
	import lscc_pkg::*;

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_KX    = 4'd1;
	localparam logic [3:0] B_KY    = 4'd2;
	localparam logic [3:0] B_DX    = 4'd3;
	localparam logic [3:0] B_DY    = 4'd4;
	localparam logic [3:0] B_T     = 4'd5;
	localparam logic [3:0] B_TT    = 4'd6;
	localparam logic [3:0] B_JUDGE = 4'd7;
	localparam logic [3:0] B_DIV   = 4'd8;
	localparam logic [3:0] B_EMIT  = 4'd9;
	localparam logic [3:0] B_ADD   = 4'd10;
	localparam logic [4:0] DIV_LAST = 5'd29;

	logic [3:0]         state_q;
	logic signed [16:0] x_q, y_q;
	logic               last_q;
	logic [11:0]        count_q;
	logic signed [28:0] sum_x_q, sum_y_q;
	logic signed [16:0] bminx_q, bmaxx_q, bminy_q, bmaxy_q;
	logic signed [29:0] dx_q, dy_q;
	logic [59:0]        d2_q;
	logic [27:0]        t_q;
	logic               end_q, found_q;
	logic signed [16:0] cx_q, cy_q;
	logic [29:0]        num_q;
	logic [12:0]        rem_q;
	logic [4:0]         it_q;
	logic               dsel_q, dneg_q;

	logic signed [30:0] ma, mb;
	logic signed [61:0] mp;
	logic signed [17:0] wx, wy, w;
	logic               accept;
	logic [27:0]        mag_x, mag_y;
	logic [29:0]        num_x, num_y;
	logic [13:0]        rs;
	logic [12:0]        den;
	logic               qbit;
	logic [29:0]        quo;
	logic signed [16:0] qs;

	// one shared multiplier, operands chosen by state
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			B_KX: begin ma = 31'({19'b0, count_q}); mb = 31'(x_q); end
			B_KY: begin ma = 31'({19'b0, count_q}); mb = 31'(y_q); end
			B_DX: begin ma = 31'(dx_q); mb = 31'(dx_q); end
			B_DY: begin ma = 31'(dy_q); mb = 31'(dy_q); end
			B_T:  begin ma = 31'({15'b0, cfg.join_distance}); mb = 31'({19'b0, count_q}); end
			B_TT: begin ma = $signed({3'b000, t_q}); mb = $signed({3'b000, t_q}); end
			default: begin end
		endcase
	end
	assign mp = ma * mb;

	assign wx = 18'(bmaxx_q) - 18'(bminx_q);
	assign wy = 18'(bmaxy_q) - 18'(bminy_q);
	assign w  = (wx > wy) ? wx : wy;
	assign accept = (count_q != '0) && (count_q >= cfg.pts_min) &&
		(count_q <= cfg.pts_max) && (w >= $signed({1'b0, cfg.min_width})) &&
		(w <= $signed({1'b0, cfg.max_width}));

	// rounded quotient: (2|s| + n) / 2n
	assign mag_x = 28'(sum_x_q < 0 ? -sum_x_q : sum_x_q);
	assign mag_y = 28'(sum_y_q < 0 ? -sum_y_q : sum_y_q);
	assign num_x = {1'b0, mag_x, 1'b0} + 30'(count_q);
	assign num_y = {1'b0, mag_y, 1'b0} + 30'(count_q);
	assign den   = {count_q, 1'b0};
	assign rs    = {rem_q, num_q[29]};
	assign qbit  = (rs >= 14'(den));
	assign quo   = {num_q[28:0], qbit};
	assign qs    = dneg_q ? -17'(quo) : 17'(quo);

	assign pt_pop   = (state_q == B_IDLE) && !pt_empty;
	assign res_push = (state_q == B_EMIT) && !res_full;
	assign res.cx       = cx_q;
	assign res.cy       = cy_q;
	assign res.found    = found_q;
	assign res.scan_end = end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			bminx_q <= COORD_MAX;
			bminy_q <= COORD_MAX;
			bmaxx_q <= COORD_MIN;
			bmaxy_q <= COORD_MIN;
			end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!pt_empty) begin
						if (pt.ok) begin
							state_q <= (count_q != '0) ? B_KX : B_ADD;
							end_q   <= 1'b0;
						end else if (pt.last) begin
							end_q   <= 1'b1;
							state_q <= B_JUDGE;
						end
					end
				end
				B_KX: state_q <= B_KY;
				B_KY: state_q <= B_DX;
				B_DX: state_q <= B_DY;
				B_DY: state_q <= B_T;
				B_T:  state_q <= B_TT;
				B_TT: state_q <= (d2_q > 60'(mp)) ? B_JUDGE : B_ADD;
				B_JUDGE: begin
					if (accept || end_q) begin
						state_q <= accept ? B_DIV : B_EMIT;
					end else begin
						count_q <= '0;
						sum_x_q <= '0;
						sum_y_q <= '0;
						bminx_q <= COORD_MAX;
						bminy_q <= COORD_MAX;
						bmaxx_q <= COORD_MIN;
						bmaxy_q <= COORD_MIN;
						state_q <= B_ADD;
					end
				end
				B_DIV: begin
					if (it_q == DIV_LAST && dsel_q) state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (!res_full) begin
						count_q <= '0;
						sum_x_q <= '0;
						sum_y_q <= '0;
						bminx_q <= COORD_MAX;
						bminy_q <= COORD_MAX;
						bmaxx_q <= COORD_MIN;
						bmaxy_q <= COORD_MIN;
						state_q <= end_q ? B_IDLE : B_ADD;
					end
				end
				B_ADD: begin
					if (count_q < COUNT_MAX) begin
						sum_x_q <= sum_x_q + 29'(x_q);
						sum_y_q <= sum_y_q + 29'(y_q);
						count_q <= count_q + 1'b1;
					end
					if (x_q < bminx_q) bminx_q <= x_q;
					if (x_q > bmaxx_q) bmaxx_q <= x_q;
					if (y_q < bminy_q) bminy_q <= y_q;
					if (y_q > bmaxy_q) bmaxy_q <= y_q;
					if (last_q) begin
						end_q   <= 1'b1;
						state_q <= B_JUDGE;
					end else begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				x_q    <= pt.x;
				y_q    <= pt.y;
				last_q <= pt.last;
			end
			B_KX: dx_q <= 30'(mp) - 30'(sum_x_q);
			B_KY: dy_q <= 30'(mp) - 30'(sum_y_q);
			B_DX: d2_q <= 60'(mp);
			B_DY: d2_q <= d2_q + 60'(mp);
			B_T:  t_q  <= 28'(mp);
			B_JUDGE: begin
				found_q <= 1'b0;
				cx_q    <= '0;
				cy_q    <= '0;
				num_q   <= num_x;
				rem_q   <= '0;
				it_q    <= '0;
				dsel_q  <= 1'b0;
				dneg_q  <= (sum_x_q < 0);
			end
			B_DIV: begin
				if (it_q == DIV_LAST && !dsel_q) begin
					// x quotient done, start on y
					cx_q   <= qs;
					num_q  <= num_y;
					rem_q  <= '0;
					it_q   <= '0;
					dsel_q <= 1'b1;
					dneg_q <= (sum_y_q < 0);
				end else begin
					num_q <= quo;
					rem_q <= qbit ? 13'(rs - 14'(den)) : 13'(rs);
					it_q  <= it_q + 1'b1;
					if (it_q == DIV_LAST) begin
						cy_q    <= qs;
						found_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/lidar_scan_cluster_centroids.sv -----
// Top level of the lidar scan clustering block: config registers, front, back, queues.
// Depends on lscc_pkg, lscc_front, lscc_back, lscc_queue.
//
//  channel   handshake            payload
//  input     push / full          range_mm, range_ok, scan_last
//  result    pop / empty          mean_x, mean_y, found, scan_end
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A valid sample holds the front end through multiply, AW-22 = 6 angle reduction
// steps, fold, 20 CORDIC steps, scaling and hand-off, so the input takes one sample
// at a time; the CORDIC loop is its longest part. An invalid sample goes from idle
// straight to hand-off. The back end runs each point through idle, the multiply
// states and add (idle and add alone when it opens a cluster); a reported cluster
// adds judge, two 30-step serial divides and emit. No clearing pass after reset.
// A full result queue stalls the back end; a full point queue stalls the front.
module lidar_scan_cluster_centroids #(
	parameter int MAX_SAMPLES = lscc_pkg::MAX_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [15:0]        range_mm,
	input  logic               range_ok,
	input  logic               scan_last,
	output logic               empty,
	input  logic               pop,
	output logic signed [16:0] mean_x,
	output logic signed [16:0] mean_y,
	output logic               found,
	output logic               scan_end,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [22:0]        cfg_data
);
	import lscc_pkg::*;

	cfg_t    cfg_q;
	point_t  fe_pt, be_pt;
	result_t be_res, out_res;
	logic    fe_push, ptq_full, ptq_empty, be_pop, be_push, resq_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_angle   <= '0;
			cfg_q.angle_step    <= 16'd1048;
			cfg_q.join_distance <= 16'd500;
			cfg_q.pts_min       <= 12'd3;
			cfg_q.pts_max       <= 12'd100;
			cfg_q.min_width     <= 17'd50;
			cfg_q.max_width     <= 17'd350;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_ANGLE:   cfg_q.start_angle   <= $signed(cfg_data);
				REG_ANGLE_STEP:    cfg_q.angle_step    <= cfg_data[15:0];
				REG_JOIN_DISTANCE: cfg_q.join_distance <= cfg_data[15:0];
				REG_MIN_POINTS:    cfg_q.pts_min       <= cfg_data[11:0];
				REG_MAX_POINTS:    cfg_q.pts_max       <= cfg_data[11:0];
				REG_MIN_WIDTH:     cfg_q.min_width     <= cfg_data[16:0];
				REG_MAX_WIDTH:     cfg_q.max_width     <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	lscc_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.push(push), .full(full),
		.range_mm(range_mm), .range_ok(range_ok), .scan_last(scan_last),
		.pt_push(fe_push), .pt(fe_pt), .pt_full(ptq_full)
	);

	lscc_queue #(.T(point_t), .DEPTH(2)) u_ptq (
		.clk(clk), .arst_n(arst_n),
		.wr_en(fe_push), .wr_data(fe_pt), .full(ptq_full),
		.rd_en(be_pop), .rd_data(be_pt), .empty(ptq_empty)
	);

	lscc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.pt_empty(ptq_empty), .pt(be_pt), .pt_pop(be_pop),
		.res_push(be_push), .res(be_res), .res_full(resq_full)
	);

	lscc_queue #(.T(result_t), .DEPTH(2)) u_resq (
		.clk(clk), .arst_n(arst_n),
		.wr_en(be_push), .wr_data(be_res), .full(resq_full),
		.rd_en(pop), .rd_data(out_res), .empty(empty)
	);

	assign mean_x   = out_res.cx;
	assign mean_y   = out_res.cy;
	assign found    = out_res.found;
	assign scan_end = out_res.scan_end;

endmodule

// ----- hw/rtl/lscc_checker.sv -----
// Port-level checks of the clustering block, bound to the top level.
// Depends on lidar_scan_cluster_centroids_macros.svh.
`include "lidar_scan_cluster_centroids_macros.svh"

module lscc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [16:0] mean_x,
	input logic [16:0] mean_y,
	input logic        found,
	input logic        scan_end
);

	logic [35:0] out_word;

	assign out_word = {mean_x, mean_y, found, scan_end};

	// a waiting word holds until taken
	`LSCC_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_word))

	// only the end-of-scan word may carry no cluster
	`LSCC_ASSERT_IMP(a_nofound_end, clk, arst_n, !empty && !found, scan_end)

	`LSCC_ASSERT_IMP(a_nofound_zero, clk, arst_n, !empty && !found, mean_x == 17'd0 && mean_y == 17'd0)

	// one sample at a time in the front end
	`LSCC_ASSERT_NXT(a_busy, clk, arst_n, push && !full, full)

	`LSCC_ASSERT_RST(a_reset, clk, !arst_n, empty && !full)

endmodule

bind lidar_scan_cluster_centroids lscc_checker u_lscc_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .empty(empty), .pop(pop),
	.mean_x(mean_x), .mean_y(mean_y), .found(found), .scan_end(scan_end)
);
